// File: hdl/aes_pkg.sv
// Package: AES constants, op codes, S-box tables and round functions.
package aes_pkg;

  localparam int MaxRounds = 14;
  localparam int StoreDepth = 2 * (MaxRounds + 1);
  localparam int SlotW = $clog2(StoreDepth);
  localparam int RoundW = $clog2(MaxRounds + 1);
  localparam int MinRounds = 10;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_ENC = 2'd1;
  localparam logic [1:0] OP_DEC = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  typedef logic [127:0] block_t;

  typedef struct packed {
    logic        decrypt;
    logic        first;
    logic        last;
    logic [127:0] data;
  } rnd_ctl_t;

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) p = p ^ x;
      x = xt(x);
    end
    gmul = p;
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    sbox = t[x];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };
    inv_sbox = t[x];
  endfunction

  function automatic logic [7:0] byte_at(input block_t s, input int i);
    byte_at = s[127 - 8 * i -: 8];
  endfunction

  // Byte i of the block is row i%4, column i/4.
  function automatic block_t enc_round(input block_t s, input logic mix);
    block_t t;
    logic [7:0] a [4];
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[127 - 8 * (r + 4 * c) -: 8] = sbox(byte_at(s, r + 4 * ((c + r) & 3)));
      end
    end
    if (mix) begin
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) a[r] = byte_at(t, 4 * c + r);
        for (int r = 0; r < 4; r++) begin
          t[127 - 8 * (4 * c + r) -: 8] = gmul(a[r], 4'd2) ^ gmul(a[(r + 1) & 3], 4'd3)
                                         ^ a[(r + 2) & 3] ^ a[(r + 3) & 3];
        end
      end
    end
    enc_round = t;
  endfunction

  function automatic block_t dec_shift_sub(input block_t s);
    block_t t;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[127 - 8 * (r + 4 * ((c + r) & 3)) -: 8] = inv_sbox(byte_at(s, r + 4 * c));
      end
    end
    dec_shift_sub = t;
  endfunction

  function automatic block_t inv_mix(input block_t s);
    block_t t;
    logic [7:0] a [4];
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) a[r] = byte_at(s, 4 * c + r);
      for (int r = 0; r < 4; r++) begin
        t[127 - 8 * (4 * c + r) -: 8] = gmul(a[r], 4'd14) ^ gmul(a[(r + 1) & 3], 4'd11)
                                       ^ gmul(a[(r + 2) & 3], 4'd13) ^ gmul(a[(r + 3) & 3], 4'd9);
      end
    end
    inv_mix = t;
  endfunction

endpackage

// File: hdl/aes_key_store.sv
// Round key store: 30 x 64-bit halves, one write port, one 128-bit registered read.
module aes_key_store (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [aes_pkg::SlotW-1:0]  wr_slot,
  input  logic [63:0]                wr_data,
  input  logic [aes_pkg::RoundW-1:0] rd_round,
  output aes_pkg::block_t            rd_key
);

  logic [63:0] mem_hi [aes_pkg::MaxRounds + 1];
  logic [63:0] mem_lo [aes_pkg::MaxRounds + 1];

  always_ff @(posedge clk) begin
    if (wr_en && !wr_slot[0]) mem_hi[wr_slot[aes_pkg::SlotW-1:1]] <= wr_data;
    if (wr_en && wr_slot[0]) mem_lo[wr_slot[aes_pkg::SlotW-1:1]] <= wr_data;
    rd_key <= {mem_hi[rd_round], mem_lo[rd_round]};
  end

endmodule

// File: hdl/aes_round_unit.sv
// Shared round unit: one fwd/inv AES round per step cycle on the state register.
module aes_round_unit (
  input  logic              clk,
  input  aes_pkg::rnd_ctl_t ctl,
  input  logic              step,
  input  aes_pkg::block_t   rkey,
  output aes_pkg::block_t   state
);

  aes_pkg::block_t state_next;
  aes_pkg::block_t f;

  always_comb begin
    f = aes_pkg::dec_shift_sub(state) ^ rkey;
    if (ctl.decrypt) begin
      state_next = ctl.last ? f : aes_pkg::inv_mix(f);
    end else begin
      state_next = aes_pkg::enc_round(state, !ctl.last) ^ rkey;
    end
    if (ctl.first) state_next = ctl.data ^ rkey;
  end

  always_ff @(posedge clk) begin
    if (step) state <= state_next;
  end

endmodule

// File: hdl/aes_block_cipher_core_unit.sv
// Top level: AES encrypt/decrypt core with round key store, sequencer and shared round unit.
//  channel | dir | fields
//  s_axis  | in  | tdata: op[1:0] key_slot[6:2] key_word[70:7] block_hi[134:71] block_lo[198:135]
//  m_axis  | out | tdata: result_hi[63:0] result_lo[127:64]
//  cfg     | in  | round_count (4 bits), written when cfg_we is high
// A block item holds the core from the accept cycle (first round key read) through the initial key
// addition and Nr rounds in the shared round unit to the result, which is held while m_axis_tready
// is low; Nr is round_count clamped to 10..14.
// A load item leaves s_axis_tready high. s_axis_tready is low while a block runs or a result waits.
// rst clears the sequencer and round_count to 10; the key store is not cleared.
module aes_block_cipher_core_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [199:0] s_axis_tdata,  // op, key_slot, key_word, block_hi, block_lo, zero pad
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,  // result_hi, result_lo
  input  logic         cfg_we,
  input  logic [3:0]   cfg_wdata
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0] st;
  logic [3:0] round_count;
  logic [aes_pkg::RoundW-1:0] nr;
  logic [aes_pkg::RoundW-1:0] cnt;
  logic [aes_pkg::RoundW-1:0] rd_round;
  logic decrypt;
  logic first;
  aes_pkg::block_t din;
  aes_pkg::block_t rkey;
  aes_pkg::block_t state;
  aes_pkg::rnd_ctl_t ctl;
  logic acc;
  logic [1:0] op;

  assign op = s_axis_tdata[1:0];
  assign s_axis_tready = (st == ST_IDLE);
  assign acc = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (st == ST_OUT);
  assign m_axis_tdata = {state[63:0], state[127:64]};

  always_comb begin
    if (round_count < 4'(aes_pkg::MinRounds)) nr = aes_pkg::RoundW'(aes_pkg::MinRounds);
    else if (round_count > 4'(aes_pkg::MaxRounds)) nr = aes_pkg::RoundW'(aes_pkg::MaxRounds);
    else nr = round_count;
  end

  // round index to read: counts 0..nr for encrypt, nr..0 for decrypt
  always_comb begin
    if (st == ST_IDLE) rd_round = (op == aes_pkg::OP_DEC) ? nr : '0;
    else if (decrypt) rd_round = nr - cnt - 1'b1;
    else rd_round = cnt + 1'b1;
  end

  aes_key_store u_store (
    .clk(clk),
    .wr_en(acc && op == aes_pkg::OP_LOAD && s_axis_tdata[6:2] < 5'(aes_pkg::StoreDepth)),
    .wr_slot(s_axis_tdata[6:2]),
    .wr_data(s_axis_tdata[70:7]),
    .rd_round(rd_round),
    .rd_key(rkey)
  );

  assign ctl.decrypt = decrypt;
  assign ctl.first = first;
  assign ctl.last = (cnt == nr);
  assign ctl.data = din;

  aes_round_unit u_round (
    .clk(clk),
    .ctl(ctl),
    .step(st == ST_RUN),
    .rkey(rkey),
    .state(state)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
      round_count <= 4'(aes_pkg::MinRounds);
      cnt <= '0;
      first <= 1'b0;
      decrypt <= 1'b0;
    end else begin
      if (cfg_we) round_count <= cfg_wdata;
      unique case (st)
        ST_IDLE: begin
          if (acc && (op == aes_pkg::OP_ENC || op == aes_pkg::OP_DEC)) begin
            st <= ST_RUN;
            decrypt <= (op == aes_pkg::OP_DEC);
            first <= 1'b1;
            cnt <= '0;
          end
        end
        ST_RUN: begin
          first <= 1'b0;
          cnt <= cnt + 1'b1;
          if (cnt == nr) st <= ST_OUT;
        end
        ST_OUT: begin
          if (m_axis_tready) st <= ST_IDLE;
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (acc) din <= {s_axis_tdata[134:71], s_axis_tdata[198:135]};
  end

  assert property (@(posedge clk) disable iff (rst) !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while a result waits");
  assert property (@(posedge clk) disable iff (rst) st == ST_RUN |-> cnt <= nr)
    else $error("round count overrun");
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (rst) first |-> st == ST_RUN && cnt == '0)
    else $error("first round out of place");

endmodule
